// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define AIR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("air assertion failed");

// Checked at every rising edge, reset included.
`define AIR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("air assertion failed");

`endif

// ===== hdl/air_pkg.sv =====
`default_nettype none
package air_pkg;

  localparam logic [3:0] COND_ALWAYS = 4'hE;

  // Class masks and match values, in priority order.
  localparam logic [31:0] BRANCH_MASK   = 32'h0E000000;
  localparam logic [31:0] BRANCH_MATCH  = 32'h0A000000;
  localparam logic [31:0] BRANCH_TRAP   = 32'h0C000000;
  localparam logic [31:0] MRS_MASK      = 32'h0FBF0FFF;
  localparam logic [31:0] MRS_MATCH     = 32'h010F0000;
  localparam logic [31:0] MRS_TRAP      = 32'h01A00090;
  localparam logic [31:0] MSR_MASK      = 32'h0FB0FFF0;
  localparam logic [31:0] MSR_MATCH     = 32'h0120F000;
  localparam logic [31:0] MSR_TRAP      = 32'h01800090;
  localparam logic [31:0] BX_MASK       = 32'h0FFFFFF0;
  localparam logic [31:0] BX_MATCH      = 32'h012FFF10;
  localparam logic [31:0] BX_TRAP       = 32'h01B00090;
  localparam logic [31:0] LDM_PC_MASK   = 32'h0E108000;
  localparam logic [31:0] LDM_PC_MATCH  = 32'h08108000;
  localparam logic [31:0] LDM_PC_TRAP   = 32'h06400010;
  localparam logic [31:0] LDM_WB_MASK   = 32'h0E300000;
  localparam logic [31:0] LDM_WB_MATCH  = 32'h08300000;
  localparam logic [31:0] LDR_PC_MASK   = 32'h0C50F000;
  localparam logic [31:0] LDR_PC_MATCH  = 32'h0410F000;
  localparam logic [31:0] LDR_PC_TRAP   = 32'h0E800010;
  localparam logic [31:0] ALU_REG_MASK  = 32'h0E00F010;
  localparam logic [31:0] ALU_ISH_MATCH = 32'h0000F000;
  localparam logic [31:0] ALU_RSH_MATCH = 32'h0000F010;
  localparam logic [31:0] ALU_IMM_MASK  = 32'h0E00F000;
  localparam logic [31:0] ALU_IMM_MATCH = 32'h0200F000;
  localparam logic [31:0] ALU_ISH_TRAP  = 32'h0E000000;
  localparam logic [31:0] ALU_IMM_TRAP  = 32'h0E400000;
  localparam logic [31:0] MOVS_PC_MATCH = 32'h01B0F000;
  localparam logic [31:0] MOVS_PC_TRAP  = 32'h0E640000;
  localparam logic [31:0] SWI_MASK      = 32'h0F000000;
  localparam logic [31:0] SWI_MATCH     = 32'h0F000000;
  localparam logic [23:0] SWI_EXIT_A    = 24'h000000;
  localparam logic [23:0] SWI_EXIT_B    = 24'h260000;

  typedef struct packed {
    logic [31:0] patched_word;
    logic        keep_scanning;
    logic        unsupported;
  } result_t;

  // Moves the ALU fields (cond, opcode, S, Rn, operand2) into the trap layout.
  function automatic logic [31:0] alu_repack(input logic [31:0] base, input logic [31:0] w);
    alu_repack = base
               | {w[31:28], 28'h0}
               | {10'h0, w[20], w[24:21], 17'h0}
               | {15'h0, w[11:0], 5'h0}
               | {28'h0, w[19:16]};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/air_rewrite.sv =====
`default_nettype none
module air_rewrite
  import air_pkg::*;
(
  input  wire logic [31:0] word,
  output result_t          res
);

  logic        cond_al;
  logic        ends;
  logic        unsup;
  logic [31:0] patched;
  logic [15:0] base_bit;
  logic [15:0] below_base;

  assign cond_al    = (word[31:28] == COND_ALWAYS);
  assign base_bit   = 16'(16'd1 << word[19:16]);
  assign below_base = base_bit - 16'd1;

  always_comb begin
    patched = word;
    ends    = 1'b0;
    unsup   = 1'b0;
    if ((word & BRANCH_MASK) == BRANCH_MATCH) begin
      patched = (word & ~BRANCH_MASK) | BRANCH_TRAP;
      ends    = 1'b1;
    end else if ((word & MRS_MASK) == MRS_MATCH) begin
      patched = MRS_TRAP | (word & 32'hF0400000) | {28'h0, word[15:12]};
    end else if ((word & MSR_MASK) == MSR_MATCH) begin
      patched = MSR_TRAP | (word & 32'hF04F000F) | {11'h0, word[25], 20'h0};
    end else if ((word & BX_MASK) == BX_MATCH) begin
      patched = BX_TRAP | (word & 32'hF000000F);
      ends    = 1'b1;
    end else if ((word & LDM_PC_MASK) == LDM_PC_MATCH) begin
      patched = LDM_PC_TRAP
              | (word & 32'hF1A00000)
              | {28'h0, word[19:16]}
              | {12'h0, word[14:0], 5'h0};
      ends    = 1'b1;
    end else if ((word & LDM_WB_MASK) == LDM_WB_MATCH) begin
      // Writeback is dropped when the base register is the lowest one loaded.
      if (((word[15:0] & base_bit) != 16'h0) && ((word[15:0] & below_base) == 16'h0)) begin
        patched = word & ~32'h00200000;
      end
    end else if ((word & LDR_PC_MASK) == LDR_PC_MATCH) begin
      if (!word[24]) begin
        unsup = 1'b1;
      end else begin
        patched = LDR_PC_TRAP
                | (word & 32'hF0200000)
                | {28'h0, word[19:16]}
                | {23'h0, word[3:0], 5'h0}
                | {12'h0, word[11:4], 12'h0}
                | {21'h0, word[24:23], 9'h0}
                | {9'h0, word[25], 22'h0};
      end
      ends = 1'b1;
    end else if ((word & ALU_REG_MASK) == ALU_ISH_MATCH) begin
      if (((word & BX_MASK) == MOVS_PC_MATCH) && (word[3:0] != 4'hF)) begin
        patched = MOVS_PC_TRAP | (word & 32'hF000000F);
      end else begin
        patched = alu_repack(ALU_ISH_TRAP, word);
      end
      ends = 1'b1;
    end else if ((word & ALU_REG_MASK) == ALU_RSH_MATCH) begin
      unsup = 1'b1;
      ends  = 1'b1;
    end else if ((word & ALU_IMM_MASK) == ALU_IMM_MATCH) begin
      patched = alu_repack(ALU_IMM_TRAP, word);
      ends    = 1'b1;
    end else if ((word & SWI_MASK) == SWI_MATCH) begin
      if ((word[23:0] == SWI_EXIT_A) || (word[23:0] == SWI_EXIT_B)) begin
        ends = 1'b1;
      end
    end
  end

  assign res.patched_word  = patched;
  assign res.keep_scanning = !(ends && cond_al);
  assign res.unsupported   = unsup;

endmodule
`default_nettype wire

// ===== hdl/arm_instruction_rewriter.sv =====
// Each accepted input beat passes the input and then the result register.
// Throughput: one instruction word per cycle; the input and result registers
// each hold when the side after them stalls.
// Reset: synchronous, active low; it empties both stages and keeps
// no other state.
`default_nettype none
module arm_instruction_rewriter
  import air_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_instruction_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_patched_word,
  output logic             out_keep_scanning,
  output logic             out_unsupported
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [31:0] s1_word_r;
  logic        s2_valid_r;
  logic        s2_valid_nxt;
  result_t     s2_res_r;
  result_t     rewrite_res;
  logic        s1_ready;
  logic        s2_ready;

  // A stage may load when it is empty or its beat leaves this cycle.
  assign s2_ready = !s2_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  assign s1_valid_nxt = s1_ready ? in_valid : s1_valid_r;
  assign s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;

  air_rewrite u_rewrite (
    .word (s1_word_r),
    .res  (rewrite_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_word_r <= in_instruction_word;
    end
    if (s1_valid_r && s2_ready) begin
      s2_res_r <= rewrite_res;
    end
  end

  assign out_valid         = s2_valid_r;
  assign out_patched_word  = s2_res_r.patched_word;
  assign out_keep_scanning = s2_res_r.keep_scanning;
  assign out_unsupported   = s2_res_r.unsupported;

endmodule
`default_nettype wire

// ===== hdl/air_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module air_checker
  import air_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_patched_word,
  input wire logic        out_keep_scanning,
  input wire logic        out_unsupported
);

  // The pipeline is empty right after a reset cycle.
  `AIR_ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> !out_valid)

  // A stalled result beat stays put.
  `AIR_ASSERT(a_stall_holds, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_patched_word))

  // Every rewrite keeps the condition field, so a stop needs an always condition.
  `AIR_ASSERT(a_stop_needs_al, clk, rst_n,
    out_valid && !out_keep_scanning |-> out_patched_word[31:28] == COND_ALWAYS)

  // Unsupported words are control transfers: with an always condition they stop.
  `AIR_ASSERT(a_unsup_stops, clk, rst_n,
    out_valid && out_unsupported && out_patched_word[31:28] == COND_ALWAYS |-> !out_keep_scanning)

  // With the result side free, the input side is never stalled.
  `AIR_ASSERT(a_no_stall_when_free, clk, rst_n,
    !out_stall && $past(!out_stall) |-> !in_stall)

endmodule

bind arm_instruction_rewriter air_checker u_air_checker (.*);
`default_nettype wire

// ===== tb/tb_arm_instruction_rewriter.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_arm_instruction_rewriter
  import air_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_CAP = 40;
  localparam logic [31:0] MOVS_FORM_MASK = 32'h0FFFFFF0;
  localparam logic [31:0] SWI_FIELD_MASK = 32'h00FFFFFF;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [31:0] in_instruction_word;
  logic out_valid;
  logic out_stall;
  logic [31:0] out_patched_word;
  logic out_keep_scanning;
  logic out_unsupported;

  result_t pending_rewrites[$];
  int error_count = 0;
  int words_checked = 0;
  int scans_ended = 0;
  int unsupported_seen = 0;
  int cycle_count = 0;
  bit tx_gaps_on;
  bit rx_gaps_on;
  int hold_requests = 0;
  int hold_served = 0;

  arm_instruction_rewriter u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_instruction_word(in_instruction_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_patched_word   (out_patched_word),
    .out_keep_scanning  (out_keep_scanning),
    .out_unsupported    (out_unsupported)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycle_count,
               pending_rewrites.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Most gaps are short; a few are long enough to drain or fill the pipeline.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Moves cond, opcode, S, Rn and operand2 of a data-processing word into the trap layout.
  function automatic logic [31:0] pack_alu_fields(input logic [31:0] trap,
                                                  input logic [31:0] w);
    return trap | {w[31:28], 6'b0, w[20], w[24:21], w[11:0], 1'b0, w[19:16]};
  endfunction

  function automatic result_t predict_rewrite(input logic [31:0] w);
    result_t r;
    logic stops;
    logic [31:0] below_base;
    logic [3:0] rn;
    r.patched_word = w;
    r.unsupported = 1'b0;
    stops = 1'b0;
    rn = w[19:16];
    below_base = (32'd1 << rn) - 32'd1;
    if ((w & BRANCH_MASK) == BRANCH_MATCH) begin
      r.patched_word = {w[31:28], 3'b110, w[24:0]};
      stops = 1'b1;
    end else if ((w & MRS_MASK) == MRS_MATCH) begin
      r.patched_word = MRS_TRAP | {w[31:28], 5'b0, w[22], 18'b0, w[15:12]};
    end else if ((w & MSR_MASK) == MSR_MATCH) begin
      r.patched_word = MSR_TRAP |
                       {w[31:28], 5'b0, w[22], 1'b0, w[25], w[19:16], 12'b0, w[3:0]};
    end else if ((w & BX_MASK) == BX_MATCH) begin
      r.patched_word = BX_TRAP | {w[31:28], 24'b0, w[3:0]};
      stops = 1'b1;
    end else if ((w & LDM_PC_MASK) == LDM_PC_MATCH) begin
      r.patched_word = LDM_PC_TRAP |
                       {w[31:28], 3'b0, w[24:23], 1'b0, w[21], 1'b0, w[14:0], 1'b0, w[19:16]};
      stops = 1'b1;
    end else if ((w & LDM_WB_MASK) == LDM_WB_MATCH) begin
      // Writeback is dropped only when the base is the lowest register loaded.
      if (w[rn] && (w & below_base) == 32'd0) r.patched_word[21] = 1'b0;
    end else if ((w & LDR_PC_MASK) == LDR_PC_MATCH) begin
      if (!w[24]) begin
        r.unsupported = 1'b1;
      end else begin
        r.patched_word = LDR_PC_TRAP |
                         {w[31:28], 5'b0, w[25], w[21], 1'b0, w[11:4], 1'b0, w[24:23],
                          w[3:0], 1'b0, w[19:16]};
      end
      stops = 1'b1;
    end else if ((w & ALU_REG_MASK) == ALU_ISH_MATCH) begin
      if ((w & MOVS_FORM_MASK) == MOVS_PC_MATCH && w[3:0] != 4'hF) begin
        r.patched_word = MOVS_PC_TRAP | {w[31:28], 24'b0, w[3:0]};
      end else begin
        r.patched_word = pack_alu_fields(ALU_ISH_TRAP, w);
      end
      stops = 1'b1;
    end else if ((w & ALU_REG_MASK) == ALU_RSH_MATCH) begin
      r.unsupported = 1'b1;
      stops = 1'b1;
    end else if ((w & ALU_IMM_MASK) == ALU_IMM_MATCH) begin
      r.patched_word = pack_alu_fields(ALU_IMM_TRAP, w);
      stops = 1'b1;
    end else if ((w & SWI_MASK) == SWI_MATCH) begin
      if (w[23:0] == SWI_EXIT_A || w[23:0] == SWI_EXIT_B) stops = 1'b1;
    end
    r.keep_scanning = !(stops && w[31:28] == COND_ALWAYS);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= REPORT_CAP) begin
      $display("MISMATCH beat %0d %s: got %h, wanted %h", words_checked, what, got, want);
    end
  endtask

  // Input and result beats are both taken here so that their order within an edge is fixed.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) pending_rewrites.push_back(predict_rewrite(in_instruction_word));
      if (out_valid && !out_stall) begin
        if (pending_rewrites.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_patched_word, 32'h0);
        end else begin
          want = pending_rewrites.pop_front();
          if (out_patched_word !== want.patched_word)
            report_mismatch("patched_word", out_patched_word, want.patched_word);
          if (out_keep_scanning !== want.keep_scanning)
            report_mismatch("keep_scanning", {31'h0, out_keep_scanning},
                            {31'h0, want.keep_scanning});
          if (out_unsupported !== want.unsupported)
            report_mismatch("unsupported", {31'h0, out_unsupported},
                            {31'h0, want.unsupported});
          if (!want.keep_scanning) scans_ended++;
          if (want.unsupported) unsupported_seen++;
        end
        words_checked++;
      end
    end
  end

  // Result-side backpressure: random runs, or one long hold-off when a test asks for it.
  initial begin : drive_result_stall
    int run_left;
    int hold_left;
    bit stalling;
    out_stall = 1'b0;
    run_left = 0;
    hold_left = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!rx_gaps_on || !rst_n) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = ($urandom_range(0, 2) == 0);
          run_left = stalling ? pick_gap() + 1 : $urandom_range(1, 12);
        end
        run_left--;
        out_stall <= stalling;
      end
    end
  end

  // Offers one beat and returns at the edge where it is taken.
  task automatic send_word(input logic [31:0] word);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_instruction_word <= $urandom();
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_instruction_word <= word;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rewrites.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random word, mostly forced into one of the rewrite classes.
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    logic [3:0] rn;
    w = $urandom();
    rn = w[19:16];
    case ($urandom_range(0, 13))
      0: w = (w & ~BRANCH_MASK) | BRANCH_MATCH;
      1: w = (w & ~MRS_MASK) | MRS_MATCH;
      2: w = (w & ~MSR_MASK) | MSR_MATCH;
      3: w = (w & ~BX_MASK) | BX_MATCH;
      4: w = (w & ~LDM_PC_MASK) | LDM_PC_MATCH;
      5: begin
        w = (w & ~LDM_WB_MASK) | LDM_WB_MATCH;
        if ($urandom_range(0, 3) != 0) begin
          w = w & ~((32'd1 << rn) - 32'd1);
          w[rn] = 1'b1;
        end
        if (rn != 4'hF && $urandom_range(0, 3) != 0) w[15] = 1'b0;
      end
      6: w = (w & ~LDR_PC_MASK) | LDR_PC_MATCH;
      7: w = (w & ~ALU_REG_MASK) | ALU_ISH_MATCH;
      8: begin
        w = (w & ~MOVS_FORM_MASK) | MOVS_PC_MATCH;
        if ($urandom_range(0, 3) == 0) w[3:0] = 4'hF;
      end
      9: w = (w & ~ALU_REG_MASK) | ALU_RSH_MATCH;
      10: w = (w & ~ALU_IMM_MASK) | ALU_IMM_MATCH;
      11: begin
        w = (w & ~SWI_MASK) | SWI_MATCH;
        case ($urandom_range(0, 2))
          0: w = (w & ~SWI_FIELD_MASK) | {8'h0, SWI_EXIT_A};
          1: w = (w & ~SWI_FIELD_MASK) | {8'h0, SWI_EXIT_B};
          default: ;
        endcase
      end
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) w[31:28] = COND_ALWAYS;
    return w;
  endfunction

  task automatic test_directed_words();
    logic [31:0] words[$];
    words = {32'h00000000, 32'hFFFFFFFF,
             32'hEA000010, 32'h1B00FFFF,                // branch, always and conditional
             32'hE10F3000, 32'hE14F5000,                // CPSR and SPSR reads
             32'hE129F001,                              // status write from a register
             32'hE12FFF1E, 32'h012FFF13,                // BX
             32'hE8BD8000,                              // pop with pc
             32'hE8B10006, 32'hE8B10007,                // writeback, base lowest or not
             32'hE59FF004, 32'hE49DF004,                // load pc, pre- and post-indexed
             32'hE1A0F00E, 32'hE1B0F00E, 32'hE1B0F00F,  // mov pc and both MOVS pc forms
             32'h1080F101,                              // add pc with an immediate shift
             32'hE080F211,                              // add pc with a register shift
             32'hE28FF004,                              // add pc with an immediate
             32'hEF000000, 32'hEF260000, 32'hEF123456, 32'h0F000000};
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    foreach (words[i]) send_word(words[i]);
    drain_results();
  endtask

  task automatic test_random_words(input int count);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (count) send_word(random_instruction());
    drain_results();
  endtask

  task automatic test_back_to_back(input int count);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (count) send_word(random_instruction());
    drain_results();
  endtask

  // The receiver holds off while beats keep coming, so both stages fill and the input stalls.
  task automatic test_output_holdoff(input int count);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b1;
    hold_requests++;
    repeat (count) send_word(random_instruction());
    drain_results();
  endtask

  // The sender goes quiet until every outstanding result is back, then resumes.
  task automatic test_pause_and_drain(input int count);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (count / 2) send_word(random_instruction());
    drain_results();
    repeat (count - count / 2) send_word(random_instruction());
    drain_results();
  endtask

  initial begin : run_tests
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_instruction_word = 32'h0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_words();
    test_random_words(900);
    test_back_to_back(150);
    test_output_holdoff(75);
    test_pause_and_drain(100);

    if (pending_rewrites.size() != 0)
      report_mismatch("results never delivered", pending_rewrites.size(), 32'h0);
    $display("Checked %0d rewritten words: %0d ended a scan, %0d flagged unsupported.",
             words_checked, scans_ended, unsupported_seen);
    $display("Phases: directed classes, random mix, back-to-back, output hold-off, drain.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
